### hw/rtl/nphb_pkg.sv
// ----------------------------------------------------------------------------
// nphb_pkg
// Shared constants for the NoC packet header builder: parameter defaults,
// message type codes, item kinds and register addresses.
// ----------------------------------------------------------------------------
package nphb_pkg;

  // Parameter defaults
  localparam int NUM_ROUTERS_DEF         = 16;
  localparam int DATA_BYTES_PER_ELEM_DEF = 4;
  localparam int FLIT_BYTES_DEF          = 16;

  // Field widths fixed by the header format
  localparam int LEN_W  = 13;
  localparam int CALC_W = 14;  // raw length before saturation
  localparam int MC_W   = 5;

  localparam logic [LEN_W-1:0] LEN_MAX   = 13'd8191;
  localparam logic [MC_W-1:0]  MESH_RST  = 5'd4;

  // Item kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  // Message type codes
  localparam logic [2:0] MT_REQ_A  = 3'd0;
  localparam logic [2:0] MT_REQ_B  = 3'd1;
  localparam logic [2:0] MT_RESP   = 3'd2;
  localparam logic [2:0] MT_ACK    = 3'd3;
  localparam logic [2:0] MT_DIST   = 3'd4;
  localparam logic [2:0] MT_COMP   = 3'd5;
  localparam logic [2:0] MT_BAD    = 3'd6;
  localparam logic [2:0] MT_REQ_C  = 3'd7;

  // Fixed length terms
  localparam int DATA_HDR_BYTES = 2;
  localparam int COMP_HDR_BYTES = 4;
  localparam int ACK_BYTES      = 3;

  // Register word index (paddr[2])
  localparam logic REG_MESH_COLUMNS = 1'b0;

endpackage

### hw/rtl/noc_packet_header_builder_core.sv
// ----------------------------------------------------------------------------
// noc_packet_header_builder_core
// Turns message descriptors into NoC packet headers using a router
// interface-count table held in a small synchronous memory.
// ----------------------------------------------------------------------------
// A load request writes one table entry, if its slot lies below NUM_ROUTERS.
// A packet request walks the table, reading from 1 to NUM_ROUTERS entries,
// one per cycle through the table's single read port, until an entry owns the
// destination index or the table ends. A restoring divider then splits the
// router number into row and column by mesh_columns, one step per bit of the
// router number (at least 2 steps). The flit rounding is a reciprocal multiply
// registered when the walk ends. The block takes one request at a time; a
// finished header waits in the output register while the next request is
// accepted. Table entries read as zero until loaded. mesh_columns of zero
// acts as one.
// ----------------------------------------------------------------------------
module noc_packet_header_builder_core #(
  parameter int NUM_ROUTERS         = nphb_pkg::NUM_ROUTERS_DEF,
  parameter int DATA_BYTES_PER_ELEM = nphb_pkg::DATA_BYTES_PER_ELEM_DEF,
  parameter int FLIT_BYTES          = nphb_pkg::FLIT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [2:0]  msg_type,
  input  logic [9:0]  elem_count,
  input  logic [9:0]  buffer_size,
  input  logic [7:0]  dest_index,
  input  logic [3:0]  table_slot,
  input  logic [3:0]  table_value,
  // output header channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  dest_row,
  output logic [3:0]  dest_col,
  output logic [3:0]  dest_port,
  output logic [nphb_pkg::LEN_W-1:0] length_bytes,
  output logic        packet_class,
  output logic        virtual_net,
  output logic        type_ok,
  output logic        dest_ok,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nphb_pkg::*;

  localparam int AW   = (NUM_ROUTERS > 1) ? $clog2(NUM_ROUTERS) : 1;
  localparam int SW0  = $clog2(NUM_ROUTERS * 15 + 1);
  localparam int SW   = (SW0 > 8) ? SW0 : 8;
  localparam int DVW  = (AW > 1) ? AW : 2;
  localparam int STPW = $clog2(DVW + 1);
  localparam int FL_L = $clog2(FLIT_BYTES);
  localparam int FL_S = CALC_W + FL_L;
  localparam int PW   = FL_S + CALC_W + 1;
  localparam logic [PW-1:0]   FL_M     = PW'((2**FL_S + FLIT_BYTES - 1) / FLIT_BYTES);
  localparam logic [AW-1:0]   LAST_IDX = AW'(NUM_ROUTERS - 1);
  localparam logic [STPW-1:0] LAST_STP = STPW'(DVW - 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DIV, S_FIN} state_t;

  state_t state;

  // configuration register
  logic [MC_W-1:0] mesh_columns;
  logic [MC_W-1:0] mc_eff;

  // table memory with per-entry valid bits
  logic [3:0]      mem [NUM_ROUTERS];
  logic            vld [NUM_ROUTERS];
  logic [3:0]      rd_data;
  logic            rd_vld;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [6:0]      slot_ext;
  logic [AW-1:0]   waddr;

  // request context
  logic [7:0]        dest;
  logic [AW-1:0]     idx;
  logic [SW-1:0]     sum;
  logic [SW-1:0]     sum_next;
  logic [3:0]        cnt;
  logic              hit;
  logic              found;
  logic [3:0]        port;
  logic [CALC_W-1:0] len_raw;
  logic [CALC_W-1:0] len_calc;
  logic              cls;
  logic              cls_calc;
  logic              vnet;
  logic              vnet_calc;
  logic              tok;
  logic              tok_calc;
  logic [CALC_W-1:0] dl_bytes;
  logic [CALC_W-1:0] bs_bytes;

  // divider and flit rounding
  logic [STPW-1:0]   step;
  logic [DVW-1:0]    rdvd;
  logic [MC_W-1:0]   rrem;
  logic [MC_W:0]     rr_s;
  logic              r_ge;
  logic [MC_W:0]     rr_d;
  logic [CALC_W-1:0] len_up;
  logic [PW-1:0]     fprod;
  logic [CALC_W-1:0] fq;
  logic [CALC_W:0]   rounded;
  logic [LEN_W-1:0]  len_final;

  logic in_acc;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign mc_eff   = (mesh_columns == '0) ? MC_W'(1) : mesh_columns;

  // Configuration port: always ready, one register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MESH_COLUMNS) ? {27'd0, mesh_columns} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_columns <= MESH_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MESH_COLUMNS) begin
      mesh_columns <= pwdata[MC_W-1:0];
    end
  end

  // Table write decode and read address
  assign slot_ext = {3'd0, table_slot};
  assign waddr    = slot_ext[AW-1:0];
  assign we       = in_acc && (kind == KIND_LOAD) && (slot_ext < 7'(NUM_ROUTERS));
  assign rd_addr  = (state == S_WALK) ? idx + AW'(1) : '0;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= table_value;
    end
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ROUTERS; i++) vld[i] <= 1'b0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // Type mapping for an accepted packet
  assign dl_bytes = CALC_W'(elem_count) * CALC_W'(DATA_BYTES_PER_ELEM)
                    + CALC_W'(DATA_HDR_BYTES);
  assign bs_bytes = CALC_W'(buffer_size) * CALC_W'(DATA_BYTES_PER_ELEM)
                    + CALC_W'(COMP_HDR_BYTES);

  always_comb begin
    len_calc  = '0;
    cls_calc  = 1'b0;
    vnet_calc = 1'b0;
    tok_calc  = 1'b1;
    case (msg_type)
      MT_REQ_A, MT_REQ_B, MT_REQ_C: len_calc = dl_bytes;
      MT_RESP: begin
        len_calc = dl_bytes;
        cls_calc = 1'b1;
      end
      MT_ACK: begin
        len_calc = CALC_W'(ACK_BYTES);
        cls_calc = 1'b1;
      end
      MT_DIST: begin
        len_calc  = dl_bytes;
        vnet_calc = 1'b1;
      end
      MT_COMP: begin
        len_calc  = bs_bytes;
        vnet_calc = 1'b1;
      end
      default: tok_calc = 1'b0;
    endcase
  end

  // Running-sum compare on the entry just read
  assign cnt      = rd_vld ? rd_data : 4'd0;
  assign sum_next = sum + SW'(cnt);
  assign hit      = SW'(dest) < sum_next;

  // Divider step: router number by mesh columns
  assign rr_s = {rrem, rdvd[DVW-1]};
  assign r_ge = rr_s >= {1'b0, mc_eff};
  assign rr_d = rr_s - {1'b0, mc_eff};

  // Whole flits by reciprocal multiply, exact while length + FLIT_BYTES-1 < 2^CALC_W
  assign len_up = len_raw + CALC_W'(FLIT_BYTES - 1);
  assign fprod  = PW'(len_up) * FL_M;

  // Round up and saturate
  assign rounded   = (CALC_W+1)'(fq) * (CALC_W+1)'(FLIT_BYTES);
  assign len_final = (rounded > (CALC_W+1)'(LEN_MAX)) ? LEN_MAX : rounded[LEN_W-1:0];

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // hold the header until the receiver takes it
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && kind == KIND_PACKET) begin
            dest    <= dest_index;
            len_raw <= len_calc;
            cls     <= cls_calc;
            vnet    <= vnet_calc;
            tok     <= tok_calc;
            idx     <= '0;
            sum     <= '0;
            found   <= 1'b0;
            port    <= '0;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          // advance until an entry owns the index or the table ends
          if (hit || idx == LAST_IDX) begin
            found <= hit;
            port  <= dest[3:0] - sum[3:0];
            rdvd  <= hit ? DVW'(idx) : '0;
            rrem  <= '0;
            fq    <= fprod[FL_S +: CALC_W];
            step  <= '0;
            state <= S_DIV;
          end else begin
            sum <= sum_next;
            idx <= idx + AW'(1);
          end
        end
        S_DIV: begin
          rrem <= r_ge ? rr_d[MC_W-1:0] : rr_s[MC_W-1:0];
          rdvd <= {rdvd[DVW-2:0], r_ge};
          step <= step + STPW'(1);
          if (step == LAST_STP) state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            dest_row     <= found ? 4'(rdvd) : 4'd0;
            dest_col     <= found ? rrem[3:0] : 4'd0;
            dest_port    <= found ? port : 4'd0;
            length_bytes <= tok ? len_final : '0;
            packet_class <= cls;
            virtual_net  <= vnet;
            type_ok      <= tok;
            dest_ok      <= found;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
